/* sv/brenc_pkg.sv */
// byte-run encoder package: sizes, queue command and memory port types
// shared by the front, queue, literal memory, back and top level; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package brenc_pkg;

	// packet and output word geometry
	localparam int MAX_PACKET = 128;
	localparam int OUT_BYTES  = 8;

	// literal length and run length counters hold 0..MAX_PACKET
	localparam int LEN_W = $clog2(MAX_PACKET + 1);

	// literal store: two banks, each of ROWS rows of OUT_BYTES bytes
	localparam int ROWS   = (MAX_PACKET + OUT_BYTES - 1) / OUT_BYTES;
	localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int LANE_W = (OUT_BYTES > 1) ? $clog2(OUT_BYTES) : 1;
	localparam int MEM_W  = OUT_BYTES * 8;

	// words of the longest packet (header plus MAX_PACKET bytes)
	localparam int WORDS_MAX = (MAX_PACKET + OUT_BYTES) / OUT_BYTES;
	localparam int ROWC_W    = $clog2(WORDS_MAX + 1);
	// byte position inside a packet, up to one word past its end
	localparam int POS_W     = $clog2(MAX_PACKET + OUT_BYTES + 1);

	// command queue between front and back, depth a power of two
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	// a packet to be emitted: a literal in one bank, or a repeat of one value
	typedef struct packed {
		logic             is_lit;
		logic             bank;
		logic [LEN_W-1:0] len;
		logic [7:0]       hdr;
		logic [7:0]       val;
		logic             last;
		logic             se;
	} pkt_cmd_t;

	typedef struct packed {
		logic     valid;
		pkt_cmd_t cmd;
	} cmd_push_t;

	// byte write into the literal store
	typedef struct packed {
		logic              en;
		logic              bank;
		logic [ROW_W-1:0]  row;
		logic [LANE_W-1:0] lane;
		logic [7:0]        data;
	} lit_wr_t;

	// row read from the literal store, registered data in the next cycle
	typedef struct packed {
		logic             en;
		logic             bank;
		logic [ROW_W-1:0] row;
	} lit_rd_t;

	// back has finished reading a literal bank
	typedef struct packed {
		logic en;
		logic bank;
	} lit_done_t;

endpackage

`default_nettype wire

/* sv/brenc_ifs.sv */
// byte-run encoder channel interfaces: raw byte input and packed word output
// valid/ready handshake with payload; no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface brenc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] raw_byte;
	logic       final_byte;

	modport source (output valid, output raw_byte, output final_byte, input ready);
	modport sink (input valid, input raw_byte, input final_byte, output ready);
endinterface

interface brenc_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] packed_bytes;
	logic [3:0]  byte_count;
	logic        packet_end;
	logic        stream_end;
	logic        run_last;

	modport source (output valid, output packed_bytes, output byte_count, output packet_end,
		output stream_end, output run_last, input ready);
	modport sink (input valid, input packed_bytes, input byte_count, input packet_end,
		input stream_end, input run_last, output ready);
endinterface

`default_nettype wire

/* sv/brenc_front.sv */
// byte-run encoder front: takes raw bytes, decides runs and literals,
// fills the literal store and queues packet commands; uses brenc_pkg, brenc_ifs
`timescale 1ns / 1ps
`default_nettype none

module brenc_front (
	input  logic                  clk,
	input  logic                  arst_n,
	brenc_in_if.sink              in_ch,
	input  logic                  q_full,
	input  brenc_pkg::lit_done_t  lit_done,
	output brenc_pkg::cmd_push_t  cmd_push,
	output brenc_pkg::lit_wr_t    lit_wr
);

	typedef enum logic [2:0] {
		F_MAIN,
		F_CAP,
		F_RUN,
		F_ADDA,
		F_ADDB,
		F_LIT,
		F_END
	} fstate_t;

	fstate_t                         state_q, state_d;
	logic                            fin_q, fin_d;
	logic [brenc_pkg::LEN_W-1:0]     lit_cnt_q, lit_cnt_d;
	logic [brenc_pkg::ROW_W-1:0]     wr_row_q, wr_row_d;
	logic [brenc_pkg::LANE_W-1:0]    wr_lane_q, wr_lane_d;
	logic                            bank_q, bank_d;
	logic [1:0]                      busy_q, busy_d;
	logic [7:0]                      look_first_q, look_first_d;
	logic [7:0]                      look_second_q, look_second_d;
	logic [1:0]                      look_fill_q, look_fill_d;
	logic [7:0]                      run_value_q, run_value_d;
	logic [brenc_pkg::LEN_W-1:0]     run_length_q, run_length_d;
	logic                            in_run_q, in_run_d;
	logic                            hold_v_q, hold_v_d;
	brenc_pkg::pkt_cmd_t             hold_cmd_q, hold_cmd_d;

	logic                            step_ok;
	logic                            take;
	logic                            add_v;
	logic [7:0]                      add_byte;
	logic                            lit_flush;
	logic [brenc_pkg::LEN_W-1:0]     lit_len;
	logic                            run_emit;
	logic [brenc_pkg::LEN_W-1:0]     run_len_e;
	logic                            direct;
	logic                            start_run;
	logic                            new_v;
	brenc_pkg::pkt_cmd_t             new_cmd;
	logic [brenc_pkg::LEN_W-1:0]     rl_inc;
	logic [brenc_pkg::LEN_W-1:0]     cnt_inc;

	// a step may go on when the queue has room and the bank being filled is free
	assign step_ok     = !q_full && !busy_q[bank_q];
	assign in_ch.ready = (state_q == F_MAIN) && step_ok;
	assign take        = in_ch.valid && in_ch.ready;
	assign rl_inc      = run_length_q + 1'b1;
	assign cnt_inc     = lit_cnt_q + 1'b1;

	// classification and flush sequencing
	always_comb begin
		state_d       = state_q;
		fin_d         = fin_q;
		lit_cnt_d     = lit_cnt_q;
		wr_row_d      = wr_row_q;
		wr_lane_d     = wr_lane_q;
		bank_d        = bank_q;
		busy_d        = busy_q;
		look_first_d  = look_first_q;
		look_second_d = look_second_q;
		look_fill_d   = look_fill_q;
		run_value_d   = run_value_q;
		run_length_d  = run_length_q;
		in_run_d      = in_run_q;
		hold_v_d      = hold_v_q;
		hold_cmd_d    = hold_cmd_q;
		add_v         = 1'b0;
		add_byte      = '0;
		lit_flush     = 1'b0;
		lit_len       = lit_cnt_q;
		run_emit      = 1'b0;
		run_len_e     = run_length_q;
		direct        = 1'b0;
		start_run     = 1'b0;
		new_v         = 1'b0;
		new_cmd       = '0;
		cmd_push      = '0;
		lit_wr        = '0;

		// back released a bank
		if (lit_done.en) begin
			busy_d[lit_done.bank] = 1'b0;
		end

		case (state_q)
			F_MAIN: begin
				if (take) begin
					fin_d = in_ch.final_byte;
					if (in_run_q) begin
						if (in_ch.raw_byte == run_value_q) begin
							if (rl_inc == brenc_pkg::LEN_W'(brenc_pkg::MAX_PACKET)) begin
								run_emit     = 1'b1;
								run_len_e    = rl_inc;
								in_run_d     = 1'b0;
								run_length_d = '0;
							end else begin
								run_length_d = rl_inc;
							end
						end else begin
							run_emit     = 1'b1;
							in_run_d     = 1'b0;
							run_length_d = '0;
							look_first_d = in_ch.raw_byte;
							look_fill_d  = 2'd1;
						end
					end else if (look_fill_q == 2'd0) begin
						look_first_d = in_ch.raw_byte;
						look_fill_d  = 2'd1;
					end else if (look_fill_q == 2'd1) begin
						look_second_d = in_ch.raw_byte;
						look_fill_d   = 2'd2;
					end else if (look_first_q == look_second_q &&
						look_second_q == in_ch.raw_byte) begin
						// three equal bytes open a repeat packet
						lit_flush    = (lit_cnt_q != '0);
						in_run_d     = 1'b1;
						run_value_d  = in_ch.raw_byte;
						run_length_d = brenc_pkg::LEN_W'(3);
						look_fill_d  = 2'd0;
						start_run    = (brenc_pkg::MAX_PACKET <= 3);
					end else begin
						add_v         = 1'b1;
						add_byte      = look_first_q;
						look_first_d  = look_second_q;
						look_second_d = in_ch.raw_byte;
					end
					direct = !start_run && !in_ch.final_byte;
					if (start_run) begin
						state_d = F_CAP;
					end else if (in_ch.final_byte) begin
						state_d = F_RUN;
					end
				end
			end
			F_CAP: begin
				// repeat packet already at the cap when it opens
				if (step_ok) begin
					run_emit     = 1'b1;
					in_run_d     = 1'b0;
					run_length_d = '0;
					state_d      = fin_q ? F_RUN : F_END;
				end
			end
			F_RUN: begin
				if (step_ok) begin
					if (in_run_q) begin
						run_emit     = 1'b1;
						in_run_d     = 1'b0;
						run_length_d = '0;
					end
					state_d = F_ADDA;
				end
			end
			F_ADDA: begin
				if (step_ok) begin
					if (look_fill_q != 2'd0) begin
						add_v    = 1'b1;
						add_byte = look_first_q;
					end
					state_d = F_ADDB;
				end
			end
			F_ADDB: begin
				if (step_ok) begin
					if (look_fill_q == 2'd2) begin
						add_v    = 1'b1;
						add_byte = look_second_q;
					end
					state_d = F_LIT;
				end
			end
			F_LIT: begin
				if (step_ok) begin
					lit_flush     = (lit_cnt_q != '0);
					look_first_d  = '0;
					look_second_d = '0;
					look_fill_d   = 2'd0;
					run_value_d   = '0;
					state_d       = F_END;
				end
			end
			F_END: begin
				// the held command is the last of the step
				if (step_ok) begin
					if (hold_v_q) begin
						cmd_push.valid    = 1'b1;
						cmd_push.cmd      = hold_cmd_q;
						cmd_push.cmd.last = 1'b1;
						cmd_push.cmd.se   = fin_q;
					end
					hold_v_d = 1'b0;
					fin_d    = 1'b0;
					state_d  = F_MAIN;
				end
			end
			default: begin
				state_d = F_MAIN;
			end
		endcase

		// append one byte to the open literal
		if (add_v) begin
			lit_wr.en   = 1'b1;
			lit_wr.bank = bank_q;
			lit_wr.row  = wr_row_q;
			lit_wr.lane = wr_lane_q;
			lit_wr.data = add_byte;
			if (cnt_inc == brenc_pkg::LEN_W'(brenc_pkg::MAX_PACKET)) begin
				lit_flush = 1'b1;
				lit_len   = cnt_inc;
			end else begin
				lit_cnt_d = cnt_inc;
				if (wr_lane_q == brenc_pkg::LANE_W'(brenc_pkg::OUT_BYTES - 1)) begin
					wr_lane_d = '0;
					wr_row_d  = wr_row_q + 1'b1;
				end else begin
					wr_lane_d = wr_lane_q + 1'b1;
				end
			end
		end

		// close the literal and hand its bank to the back
		if (lit_flush) begin
			new_v          = 1'b1;
			new_cmd.is_lit = 1'b1;
			new_cmd.bank   = bank_q;
			new_cmd.len    = lit_len;
			new_cmd.hdr    = 8'(lit_len) - 8'd1;
			busy_d[bank_q] = 1'b1;
			bank_d         = ~bank_q;
			lit_cnt_d      = '0;
			wr_row_d       = '0;
			wr_lane_d      = '0;
		end

		// repeat packet header is 257 minus length
		if (run_emit) begin
			new_v          = 1'b1;
			new_cmd.is_lit = 1'b0;
			new_cmd.hdr    = 8'(9'd257 - 9'(run_len_e));
			new_cmd.val    = run_value_q;
		end

		// single-command steps transfer at once, longer ones go through the hold
		if (new_v) begin
			if (direct) begin
				cmd_push.valid    = 1'b1;
				cmd_push.cmd      = new_cmd;
				cmd_push.cmd.last = 1'b1;
			end else begin
				if (hold_v_q) begin
					cmd_push.valid = 1'b1;
					cmd_push.cmd   = hold_cmd_q;
				end
				hold_cmd_d = new_cmd;
				hold_v_d   = 1'b1;
			end
		end
	end

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= F_MAIN;
			fin_q         <= 1'b0;
			lit_cnt_q     <= '0;
			wr_row_q      <= '0;
			wr_lane_q     <= '0;
			bank_q        <= 1'b0;
			busy_q        <= '0;
			look_first_q  <= '0;
			look_second_q <= '0;
			look_fill_q   <= 2'd0;
			run_value_q   <= '0;
			run_length_q  <= '0;
			in_run_q      <= 1'b0;
			hold_v_q      <= 1'b0;
		end else begin
			state_q       <= state_d;
			fin_q         <= fin_d;
			lit_cnt_q     <= lit_cnt_d;
			wr_row_q      <= wr_row_d;
			wr_lane_q     <= wr_lane_d;
			bank_q        <= bank_d;
			busy_q        <= busy_d;
			look_first_q  <= look_first_d;
			look_second_q <= look_second_d;
			look_fill_q   <= look_fill_d;
			run_value_q   <= run_value_d;
			run_length_q  <= run_length_d;
			in_run_q      <= in_run_d;
			hold_v_q      <= hold_v_d;
		end
	end

	// held command payload
	always_ff @(posedge clk) begin
		hold_cmd_q <= hold_cmd_d;
	end

endmodule

`default_nettype wire

/* sv/brenc_cmd_fifo.sv */
// byte-run encoder command queue between front and back
// small register queue of packet commands; uses brenc_pkg
`timescale 1ns / 1ps
`default_nettype none

module brenc_cmd_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  brenc_pkg::cmd_push_t cmd_push,
	output logic                 full,
	input  logic                 pop,
	output logic                 head_valid,
	output brenc_pkg::pkt_cmd_t  head
);

	brenc_pkg::pkt_cmd_t           entry_q [brenc_pkg::Q_DEPTH];
	logic [brenc_pkg::Q_AW-1:0]    wr_ptr_q;
	logic [brenc_pkg::Q_AW-1:0]    rd_ptr_q;
	logic [brenc_pkg::Q_CW-1:0]    count_q;
	logic                          do_push;
	logic                          do_pop;

	assign full       = (count_q == brenc_pkg::Q_CW'(brenc_pkg::Q_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];
	assign do_push    = cmd_push.valid && !full;
	assign do_pop     = pop && head_valid;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= cmd_push.cmd;
		end
	end

endmodule

`default_nettype wire

/* sv/brenc_lit_mem.sv */
// byte-run encoder literal store: two banks of rows of OUT_BYTES bytes
// byte-lane writes, registered row reads; uses brenc_pkg
`timescale 1ns / 1ps
`default_nettype none

module brenc_lit_mem (
	input  logic                          clk,
	input  brenc_pkg::lit_wr_t            lit_wr,
	input  brenc_pkg::lit_rd_t            lit_rd,
	output logic [brenc_pkg::MEM_W-1:0]   rd_data
);

	logic [brenc_pkg::MEM_W-1:0] mem [2][brenc_pkg::ROWS];

	// byte write
	always_ff @(posedge clk) begin
		if (lit_wr.en) begin
			mem[lit_wr.bank][lit_wr.row][lit_wr.lane*8 +: 8] <= lit_wr.data;
		end
	end

	// row read
	always_ff @(posedge clk) begin
		if (lit_rd.en) begin
			rd_data <= mem[lit_rd.bank][lit_rd.row];
		end
	end

endmodule

`default_nettype wire

/* sv/brenc_back.sv */
// byte-run encoder back: turns queued packet commands into output words
// reads literal rows from the store, one word per cycle while out_ch is ready; uses brenc_pkg, brenc_ifs
`timescale 1ns / 1ps
`default_nettype none

module brenc_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  brenc_pkg::pkt_cmd_t           q_head,
	output logic                          q_pop,
	output brenc_pkg::lit_rd_t            lit_rd,
	input  logic [brenc_pkg::MEM_W-1:0]   rd_data,
	output brenc_pkg::lit_done_t          lit_done,
	brenc_out_if.source                   out_ch
);

	logic                          active_q;
	brenc_pkg::pkt_cmd_t           cmd_q;
	logic [brenc_pkg::POS_W-1:0]   pos_q;
	logic [brenc_pkg::ROWC_W-1:0]  row_q;
	logic [7:0]                    carry_q;
	logic                          out_valid_q;
	logic [63:0]                   out_bytes_q;
	logic [3:0]                    out_count_q;
	logic                          out_pend_q;
	logic                          out_send_q;
	logic                          out_last_q;

	logic                          emit;
	logic [brenc_pkg::POS_W-1:0]   total;
	logic [brenc_pkg::POS_W-1:0]   rem;
	logic                          last_word;
	logic [3:0]                    word_cnt;
	logic [brenc_pkg::ROWC_W-1:0]  next_row;
	logic [63:0]                   rd_ext;
	logic [63:0]                   rd_shift;
	logic [63:0]                   word;

	// packet length in bytes, header included
	assign total     = cmd_q.is_lit ? (brenc_pkg::POS_W'(cmd_q.len) + 1'b1)
		: brenc_pkg::POS_W'(2);
	assign rem       = total - pos_q;
	assign last_word = (rem <= brenc_pkg::POS_W'(brenc_pkg::OUT_BYTES));
	assign word_cnt  = last_word ? 4'(rem) : 4'(brenc_pkg::OUT_BYTES);
	assign emit      = active_q && (!out_valid_q || out_ch.ready);
	assign q_pop     = q_valid && !active_q;
	assign next_row  = row_q + 1'b1;
	assign rd_ext    = 64'(rd_data);
	// row bytes moved up one lane, behind the header or carried byte
	assign rd_shift  = rd_ext << 8;

	// row 0 is fetched at the pop, each later row as the word before it leaves
	always_comb begin
		lit_rd = '0;
		if (q_pop) begin
			lit_rd.en   = q_head.is_lit;
			lit_rd.bank = q_head.bank;
			lit_rd.row  = '0;
		end else if (emit) begin
			lit_rd.en   = cmd_q.is_lit && !last_word;
			lit_rd.bank = cmd_q.bank;
			lit_rd.row  = (next_row < brenc_pkg::ROWC_W'(brenc_pkg::ROWS))
				? next_row[brenc_pkg::ROW_W-1:0] : '0;
		end
	end

	assign lit_done.en   = emit && last_word && cmd_q.is_lit;
	assign lit_done.bank = cmd_q.bank;

	// word assembly: lane 0 is the header or the byte carried from the last row
	always_comb begin
		logic [7:0] byte_v;
		word = '0;
		for (int i = 0; i < 8; i++) begin
			byte_v = 8'h00;
			if (i < brenc_pkg::OUT_BYTES && 4'(i) < word_cnt) begin
				if (i == 0) begin
					byte_v = (pos_q == '0) ? cmd_q.hdr : (cmd_q.is_lit ? carry_q : cmd_q.val);
				end else begin
					byte_v = cmd_q.is_lit ? rd_shift[i*8 +: 8] : cmd_q.val;
				end
			end
			word[i*8 +: 8] = byte_v;
		end
	end

	// packet walk and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				active_q <= 1'b1;
			end else if (emit && last_word) begin
				active_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// packet payload and output word
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_head;
			pos_q <= '0;
			row_q <= '0;
		end else if (emit) begin
			pos_q   <= pos_q + brenc_pkg::POS_W'(brenc_pkg::OUT_BYTES);
			row_q   <= next_row;
			carry_q <= rd_data[(brenc_pkg::OUT_BYTES-1)*8 +: 8];
		end
		if (emit) begin
			out_bytes_q <= word;
			out_count_q <= word_cnt;
			out_pend_q  <= last_word;
			out_send_q  <= last_word && cmd_q.se;
			out_last_q  <= last_word && cmd_q.last;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.packed_bytes = out_bytes_q;
	assign out_ch.byte_count   = out_count_q;
	assign out_ch.packet_end   = out_pend_q;
	assign out_ch.stream_end   = out_send_q;
	assign out_ch.run_last     = out_last_q;

endmodule

`default_nettype wire

/* sv/byte_run_encoder_core.sv */
// Byte-run (PackBits style) encoder: one raw byte per transfer in, packets of
// up to eight bytes per transfer out. The front takes a byte and classifies
// it; after a byte with final_byte set the front flushes the open run, the
// undecided bytes and the literal, then sends the held command. The front
// also holds off input while the command queue is full or while the literal
// bank it must fill next is still being read out: the literal store has two
// banks, so a third literal waits for the first to drain. The back sends one
// output word per cycle while the output is ready; a literal packet of n
// bytes gives ceil((n + 1) / 8) words once its first row is fetched, and a
// repeat packet gives one. The literal store needs no clearing after reset;
// the block accepts input as soon as reset is released.
// Depends on brenc_pkg, brenc_ifs, brenc_front, brenc_cmd_fifo, brenc_lit_mem,
// brenc_back.
`timescale 1ns / 1ps
`default_nettype none

module byte_run_encoder_core (
	input  logic        clk,
	input  logic        arst_n,
	brenc_in_if.sink    in_ch,
	brenc_out_if.source out_ch
);

	brenc_pkg::cmd_push_t          cmd_push;
	logic                          q_full;
	logic                          q_pop;
	logic                          q_valid;
	brenc_pkg::pkt_cmd_t           q_head;
	brenc_pkg::lit_wr_t            lit_wr;
	brenc_pkg::lit_rd_t            lit_rd;
	brenc_pkg::lit_done_t          lit_done;
	logic [brenc_pkg::MEM_W-1:0]   rd_data;

	// classification and literal fill
	brenc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.q_full   (q_full),
		.lit_done (lit_done),
		.cmd_push (cmd_push),
		.lit_wr   (lit_wr)
	);

	// packet command queue
	brenc_cmd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_push   (cmd_push),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head       (q_head)
	);

	// double-banked literal store
	brenc_lit_mem u_mem (
		.clk     (clk),
		.lit_wr  (lit_wr),
		.lit_rd  (lit_rd),
		.rd_data (rd_data)
	);

	// word packing and output register
	brenc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.lit_rd   (lit_rd),
		.rd_data  (rd_data),
		.lit_done (lit_done),
		.out_ch   (out_ch)
	);

endmodule

`default_nettype wire
